[rtl/core/mixer_output_source_routing_table_macros.svh]
// Assertion macros for the mixer output routing table.
`ifndef MIXER_OUTPUT_SOURCE_ROUTING_TABLE_MACROS_SVH
`define MIXER_OUTPUT_SOURCE_ROUTING_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property while out of reset.
`define MORT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mort assertion failed");
// Check a property on every edge, reset included.
`define MORT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mort assertion failed");
`else
`define MORT_ASSERT(name, clk, rstn, prop)
`define MORT_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/core/mort_pkg.sv]
// Shared widths, codes and types of the mixer output routing table.
package mort_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CFG_W  = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h4000;

  localparam logic [FUNC_W-1:0] FN_SET_CHAN = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_SRC  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_HAS      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CH  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_KND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [GAIN_W-1:0] gain;
  } list_word_t;

endpackage

[rtl/core/mort_if.sv]
// Request and response channel interfaces of the mixer output routing table.
interface mort_in_if;
  logic                         valid;
  logic                         ready;
  logic [mort_pkg::FUNC_W-1:0]  func;
  logic [mort_pkg::CHAN_W-1:0]  channel;
  logic [mort_pkg::KIND_W-1:0]  source_kind;
  logic [mort_pkg::GAIN_W-1:0]  gain_in;

  modport source (output valid, func, channel, source_kind, gain_in, input ready);
  modport sink   (input valid, func, channel, source_kind, gain_in, output ready);
endinterface

interface mort_out_if;
  logic                         valid;
  logic                         ready;
  logic [mort_pkg::STAT_W-1:0]  status;
  logic [mort_pkg::GAIN_W-1:0]  gain_out;
  logic                         present;

  modport source (output valid, status, gain_out, present, input ready);
  modport sink   (input valid, status, gain_out, present, output ready);
endinterface

[rtl/core/mixer_output_source_routing_table.sv]
// Mixer output routing table: per-channel source lists, gains and gain cache.
//
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      func, channel, source_kind, gain_in
//   out_o     out  valid/ready      status, gain_out, present
//   cfg       in   cfg_we_i         cfg_wdata_i (channels in use)
//
// An item is worked through by a linear scan over the list memory's single read port,
// one list slot at a time; an item that needs no scan skips it, and a remove adds
// a read and a move of the last entry. One item is in work at a time. After reset
// a clearing pass zeroes the gain cache with in_i.ready low. A waiting result holds
// in the output register while the next item is taken; a finished item stalls only
// if that register is full.
`include "mixer_output_source_routing_table_macros.svh"

module mixer_output_source_routing_table #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned KINDS    = 18,
  parameter int unsigned ENTRIES  = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mort_pkg::CFG_W-1:0] cfg_wdata_i,
  mort_in_if.sink                    in_i,
  mort_out_if.source                 out_o
);
  import mort_pkg::*;

  localparam int unsigned LIST_DEPTH  = CHANNELS * ENTRIES;
  localparam int unsigned CACHE_DEPTH = CHANNELS * KINDS;
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LA_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CA_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam logic [CHAN_W:0]  CH_LIM    = (CHAN_W + 1)'(CHANNELS);
  localparam logic [KIND_W:0]  KIND_LIM  = (KIND_W + 1)'(KINDS);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ENTRIES);
  localparam logic [CA_W-1:0]  CLR_LAST  = CA_W'(CACHE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_RDLAST = 3'd4;
  localparam logic [2:0] S_MOVE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Control state
  logic [2:0]        state_q, state_d;
  logic [CFG_W-1:0]  chan_cnt_q;
  logic [CA_W-1:0]   clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0]  srch_idx_q, srch_idx_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  act_cnt_q [CHANNELS];
  logic [GAIN_W-1:0] chan_gain_q [CHANNELS];

  // Item and result payload
  logic [FUNC_W-1:0] func_q, func_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [LA_W-1:0]   lbase_q, lbase_d;
  logic [CA_W-1:0]   caddr_q, caddr_d;
  logic [CNT_W-1:0]  pidx_q, pidx_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  slot_q, slot_d;
  logic [GAIN_W-1:0] slot_gain_q, slot_gain_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [GAIN_W-1:0] res_gain_q, res_gain_d;
  logic              res_present_q, res_present_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [GAIN_W-1:0] out_gain_q, out_gain_d;
  logic              out_present_q, out_present_d;

  // Memories
  list_word_t        list_mem [LIST_DEPTH];
  list_word_t        list_rdata_q;
  logic [LA_W-1:0]   list_raddr, list_waddr;
  logic              list_we;
  list_word_t        list_wdata;
  logic [GAIN_W-1:0] cache_mem [CACHE_DEPTH];
  logic [GAIN_W-1:0] cache_rdata_q;
  logic [CA_W-1:0]   cache_waddr;
  logic              cache_we;
  logic [GAIN_W-1:0] cache_wdata;

  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wval;
  logic              cgain_we;
  logic [CNT_W-1:0]  cnt_cur;
  logic              in_xfer, out_xfer, hit;
  logic              ch_ok, kind_ok;

  assign cnt_cur  = act_cnt_q[ch_q];
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;
  assign hit      = pend_q && (list_rdata_q.kind == kind_q);
  assign ch_ok    = ({1'b0, in_i.channel} < {1'b0, chan_cnt_q}) &&
                    ({1'b0, in_i.channel} < CH_LIM);
  assign kind_ok  = {1'b0, in_i.source_kind} < KIND_LIM;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.gain_out = out_gain_q;
  assign out_o.present  = out_present_q;

  always_comb begin
    state_d       = state_q;
    clr_idx_d     = clr_idx_q;
    srch_idx_d    = srch_idx_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    func_d        = func_q;
    ch_d          = ch_q;
    kind_d        = kind_q;
    gain_d        = gain_q;
    lbase_d       = lbase_q;
    caddr_d       = caddr_q;
    pidx_d        = pidx_q;
    found_d       = found_q;
    slot_d        = slot_q;
    slot_gain_d   = slot_gain_q;
    res_status_d  = res_status_q;
    res_gain_d    = res_gain_q;
    res_present_d = res_present_q;
    out_status_d  = out_status_q;
    out_gain_d    = out_gain_q;
    out_present_d = out_present_q;
    list_raddr    = lbase_q + LA_W'(srch_idx_q);
    list_we       = 1'b0;
    list_waddr    = lbase_q + LA_W'(slot_q);
    list_wdata    = list_rdata_q;
    cache_we      = 1'b0;
    cache_waddr   = caddr_q;
    cache_wdata   = gain_q;
    cnt_we        = 1'b0;
    cnt_wval      = cnt_cur;
    cgain_we      = 1'b0;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        cache_we    = 1'b1;
        cache_waddr = clr_idx_q;
        cache_wdata = '0;
        clr_idx_d   = clr_idx_q + CA_W'(1);
        if (clr_idx_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          func_d        = in_i.func;
          ch_d          = in_i.channel[CH_W-1:0];
          kind_d        = in_i.source_kind;
          gain_d        = in_i.gain_in;
          lbase_d       = LA_W'(int'(in_i.channel) * ENTRIES);
          caddr_d       = CA_W'(int'(in_i.channel) * KINDS + int'(in_i.source_kind));
          srch_idx_d    = '0;
          pend_d        = 1'b0;
          found_d       = 1'b0;
          res_status_d  = ST_OK;
          res_gain_d    = '0;
          res_present_d = 1'b0;
          priority if (in_i.func > FN_HAS) begin
            state_d = S_DONE;
          end else if (!ch_ok) begin
            res_status_d = ST_BAD_CH;
            state_d      = S_DONE;
          end else if (in_i.func == FN_SET_CHAN) begin
            cgain_we = 1'b1;
            state_d  = kind_ok ? S_SEARCH : S_DONE;
          end else if (!kind_ok) begin
            res_status_d = ST_BAD_KND;
            state_d      = S_DONE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // Compare last cycle's read while the next slot is fetched.
        priority if (hit) begin
          found_d     = 1'b1;
          slot_d      = pidx_q;
          slot_gain_d = list_rdata_q.gain;
          pend_d      = 1'b0;
          state_d     = S_UPDATE;
        end else if (srch_idx_q != cnt_cur) begin
          pend_d     = 1'b1;
          pidx_d     = srch_idx_q;
          srch_idx_d = srch_idx_q + CNT_W'(1);
        end else begin
          found_d = 1'b0;
          pend_d  = 1'b0;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        res_present_d = found_q;
        state_d       = S_DONE;
        unique case (func_q)
          FN_ADD: begin
            priority if (cnt_cur >= CNT_FULL) begin
              res_status_d = ST_FULL;
            end else if (found_q) begin
              res_status_d = ST_DUP;
            end else begin
              list_we       = 1'b1;
              list_waddr    = lbase_q + LA_W'(cnt_cur);
              list_wdata    = '{kind: kind_q, gain: cache_rdata_q};
              cnt_we        = 1'b1;
              cnt_wval      = cnt_cur + CNT_W'(1);
              res_present_d = 1'b1;
            end
          end
          FN_REMOVE: begin
            if (found_q) begin
              cache_we      = 1'b1;
              cache_wdata   = slot_gain_q;
              res_present_d = 1'b0;
              state_d       = S_RDLAST;
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          FN_SET_SRC: begin
            if (found_q) begin
              list_we    = 1'b1;
              list_wdata = '{kind: kind_q, gain: gain_q};
            end else begin
              cache_we = 1'b1;
            end
          end
          FN_GET: begin
            res_gain_d = found_q ? slot_gain_q : cache_rdata_q;
          end
          default: begin
          end
        endcase
      end
      S_RDLAST: begin
        list_raddr = lbase_q + LA_W'(cnt_cur - CNT_W'(1));
        state_d    = S_MOVE;
      end
      S_MOVE: begin
        // Fill the freed slot with the last entry and shrink the list.
        list_we  = 1'b1;
        cnt_we   = 1'b1;
        cnt_wval = cnt_cur - CNT_W'(1);
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_gain_d    = res_gain_q;
          out_present_d = res_present_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      chan_cnt_q  <= '0;
      clr_idx_q   <= '0;
      srch_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        act_cnt_q[i]   <= '0;
        chan_gain_q[i] <= GAIN_ONE;
      end
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      srch_idx_q  <= srch_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        chan_cnt_q <= cfg_wdata_i;
      end
      if (cnt_we) begin
        act_cnt_q[ch_q] <= cnt_wval;
      end
      if (cgain_we) begin
        chan_gain_q[in_i.channel[CH_W-1:0]] <= in_i.gain_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    ch_q          <= ch_d;
    kind_q        <= kind_d;
    gain_q        <= gain_d;
    lbase_q       <= lbase_d;
    caddr_q       <= caddr_d;
    pidx_q        <= pidx_d;
    found_q       <= found_d;
    slot_q        <= slot_d;
    slot_gain_q   <= slot_gain_d;
    res_status_q  <= res_status_d;
    res_gain_q    <= res_gain_d;
    res_present_q <= res_present_d;
    out_status_q  <= out_status_d;
    out_gain_q    <= out_gain_d;
    out_present_q <= out_present_d;
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata_q <= list_mem[list_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    cache_rdata_q <= cache_mem[caddr_q];
  end

  `MORT_ASSERT(a_clear_blocks_input, clk_i, rst_ni, (state_q == S_CLEAR) |-> !in_i.ready)
  `MORT_ASSERT(a_count_in_range, clk_i, rst_ni,
    (state_q == S_SEARCH) |-> (srch_idx_q <= cnt_cur && cnt_cur <= CNT_FULL))
  `MORT_ASSERT(a_error_clears_result, clk_i, rst_ni,
    (out_valid_q && (out_status_q == ST_BAD_CH || out_status_q == ST_BAD_KND)) |->
      (!out_present_q && out_gain_q == '0))
  `MORT_ASSERT(a_remove_moves_once, clk_i, rst_ni,
    (state_q == S_MOVE) |-> ($past(state_q) == S_RDLAST && func_q == FN_REMOVE && found_q))

endmodule

[tb/mort_route_checker.sv]
// Scoreboard for the mixer output routing table: predicts each reply and checks it.
module mort_route_checker #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned KINDS    = 18,
  parameter int unsigned ENTRIES  = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mort_pkg::CFG_W-1:0] cfg_wdata_i,
  mort_in_if                         req_if,
  mort_out_if                        rsp_if,
  output int                         fails_o,
  output int                         pending_o
);
  import mort_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [GAIN_W-1:0] gain;
    logic              present;
  } route_reply_t;

  logic [CFG_W-1:0]  chan_limit;
  logic [GAIN_W-1:0] chan_gain  [CHANNELS];
  int unsigned       list_len   [CHANNELS];
  logic [KIND_W-1:0] slot_kind  [CHANNELS][ENTRIES];
  logic [GAIN_W-1:0] slot_gain  [CHANNELS][ENTRIES];
  logic [GAIN_W-1:0] kind_cache [CHANNELS][KINDS];
  route_reply_t      replies_due [$];
  int                mismatch_cnt = 0;

  assign fails_o = mismatch_cnt;

  task automatic report(input string msg);
    // keep the log short when the design is badly off
    if (mismatch_cnt < 50) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic void clear_table();
    chan_limit = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      chan_gain[c] = GAIN_ONE;
      list_len[c]  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_kind[c][i] = '0;
        slot_gain[c][i] = '0;
      end
      for (int k = 0; k < KINDS; k++) begin
        kind_cache[c][k] = '0;
      end
    end
  endfunction

  function automatic int slot_of(input int unsigned ch, input logic [KIND_W-1:0] kind);
    for (int i = 0; i < list_len[ch]; i++) begin
      if (slot_kind[ch][i] == kind) return i;
    end
    return -1;
  endfunction

  function automatic route_reply_t apply_route_op(input logic [FUNC_W-1:0] fn,
                                                  input logic [CHAN_W-1:0] ch,
                                                  input logic [KIND_W-1:0] kind,
                                                  input logic [GAIN_W-1:0] gain);
    route_reply_t r;
    int           slot;
    int unsigned  last;
    r = '0;
    if (fn > FN_HAS) begin
      // unused codes leave the table alone
    end else if (ch >= chan_limit || ch >= CHANNELS) begin
      r.status = ST_BAD_CH;
    end else if (fn == FN_SET_CHAN) begin
      chan_gain[ch] = gain;
      r.present = (kind < KINDS) && (slot_of(ch, kind) >= 0);
    end else if (kind >= KINDS) begin
      r.status = ST_BAD_KND;
    end else begin
      slot = slot_of(ch, kind);
      r.present = (slot >= 0);
      case (fn)
        FN_ADD: begin
          // a full list wins over a duplicate
          if (list_len[ch] >= ENTRIES) begin
            r.status = ST_FULL;
          end else if (slot >= 0) begin
            r.status = ST_DUP;
          end else begin
            slot_kind[ch][list_len[ch]] = kind;
            slot_gain[ch][list_len[ch]] = kind_cache[ch][kind];
            list_len[ch]++;
            r.present = 1'b1;
          end
        end
        FN_REMOVE: begin
          if (slot < 0) begin
            r.status = ST_ABSENT;
          end else begin
            // save the gain, then move the last entry into the hole
            last = list_len[ch] - 1;
            kind_cache[ch][kind] = slot_gain[ch][slot];
            slot_kind[ch][slot]  = slot_kind[ch][last];
            slot_gain[ch][slot]  = slot_gain[ch][last];
            list_len[ch]         = last;
            r.present            = 1'b0;
          end
        end
        FN_SET_SRC: begin
          if (slot >= 0) begin
            slot_gain[ch][slot] = gain;
          end else begin
            kind_cache[ch][kind] = gain;
          end
        end
        FN_GET: begin
          r.gain = (slot >= 0) ? slot_gain[ch][slot] : kind_cache[ch][kind];
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_reply_t want;
    route_reply_t next;
    if (!rst_ni) begin
      clear_table();
      replies_due.delete();
      pending_o <= 0;
    end else begin
      // retire the reply first; it always belongs to an earlier request
      if (rsp_if.valid && rsp_if.ready) begin
        if (replies_due.size() == 0) begin
          report($sformatf("reply with none due: status %0d gain %0h present %0b",
                           rsp_if.status, rsp_if.gain_out, rsp_if.present));
        end else begin
          want = replies_due.pop_front();
          if (rsp_if.status !== want.status) begin
            report($sformatf("status %0d, want %0d", rsp_if.status, want.status));
          end
          if (rsp_if.gain_out !== want.gain) begin
            report($sformatf("gain_out %0h, want %0h", rsp_if.gain_out, want.gain));
          end
          if (rsp_if.present !== want.present) begin
            report($sformatf("present %0b, want %0b", rsp_if.present, want.present));
          end
        end
      end
      if (cfg_we_i) begin
        chan_limit = cfg_wdata_i;
      end
      if (req_if.valid && req_if.ready) begin
        next = apply_route_op(req_if.func, req_if.channel, req_if.source_kind, req_if.gain_in);
        replies_due.push_back(next);
      end
      pending_o <= replies_due.size();
    end
  end

endmodule

[tb/tb_mixer_output_source_routing_table.sv]
// Top of the routing table testbench: clock, reset, request stimulus and verdict.
module tb_mixer_output_source_routing_table;
  import mort_pkg::*;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned KINDS    = 18;
  localparam int unsigned ENTRIES  = 18;
  localparam int          LATENCY  = ENTRIES + 6;
  localparam int          LIMIT    = 1000000;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int               fails;
  int               pending;
  int unsigned      sent = 0;
  int unsigned      stall_left = 0;
  bit               steady = 1'b0;
  logic [CFG_W-1:0] chan_count = '0;

  mort_in_if  req_if ();
  mort_out_if rsp_if ();

  mixer_output_source_routing_table #(
    .CHANNELS (CHANNELS),
    .KINDS    (KINDS),
    .ENTRIES  (ENTRIES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  mort_route_checker #(
    .CHANNELS (CHANNELS),
    .KINDS    (KINDS),
    .ENTRIES  (ENTRIES)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_if      (req_if),
    .rsp_if      (rsp_if),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Reply side: random back-pressure, mostly short, now and then long.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      rsp_if.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return GAIN_W'($urandom_range(0, 65535));
  endfunction

  // Channel that the current count accepts, where there is one.
  function automatic logic [CHAN_W-1:0] pick_channel();
    int unsigned span;
    span = (chan_count == 0) ? 1 : ((chan_count > CHANNELS) ? CHANNELS : chan_count);
    return CHAN_W'($urandom_range(0, span - 1));
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [CHAN_W-1:0] ch,
                         input logic [KIND_W-1:0] kind, input logic [GAIN_W-1:0] gain);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= fn;
    req_if.channel     <= ch;
    req_if.source_kind <= kind;
    req_if.gain_in     <= gain;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Hold off until every reply is back and the block has settled.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    chan_count = value;
  endtask

  task automatic random_op();
    logic [FUNC_W-1:0] fn;
    logic [CHAN_W-1:0] ch;
    logic [KIND_W-1:0] kind;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      fn = FN_ADD;
    end else if (pick < 55) begin
      fn = FN_REMOVE;
    end else if (pick < 67) begin
      fn = FN_SET_SRC;
    end else if (pick < 80) begin
      fn = FN_GET;
    end else if (pick < 89) begin
      fn = FN_HAS;
    end else if (pick < 96) begin
      fn = FN_SET_CHAN;
    end else begin
      fn = ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
    end
    ch   = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(0, 15)) : pick_channel();
    kind = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(0, 31))
                                        : KIND_W'($urandom_range(0, KINDS - 1));
    // plain noise: any code, any channel, any type
    if ($urandom_range(0, 99) < 8) begin
      fn   = FUNC_W'($urandom_range(0, 7));
      ch   = CHAN_W'($urandom_range(0, 15));
      kind = KIND_W'($urandom_range(0, 31));
    end
    send_op(fn, ch, kind, pick_gain());
  endtask

  // Add every type in random order, push past the end, tune a few, tear part down.
  task automatic fill_channel();
    logic [KIND_W-1:0] order [KINDS];
    logic [KIND_W-1:0] t;
    logic [CHAN_W-1:0] ch;
    int unsigned       j;
    ch = pick_channel();
    for (int k = 0; k < KINDS; k++) order[k] = KIND_W'(k);
    for (int k = KINDS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < KINDS; k++) send_op(FN_ADD, ch, order[k], pick_gain());
    send_op(FN_ADD, ch, KIND_W'($urandom_range(0, KINDS - 1)), pick_gain());
    repeat ($urandom_range(1, 4)) begin
      send_op(FN_SET_SRC, ch, KIND_W'($urandom_range(0, KINDS - 1)), pick_gain());
      send_op(FN_GET, ch, KIND_W'($urandom_range(0, KINDS - 1)), '0);
    end
    for (int k = $urandom_range(0, KINDS - 1); k < KINDS; k++) begin
      send_op(FN_REMOVE, ch, order[$urandom_range(0, KINDS - 1)], pick_gain());
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    stop   = sent + n;
    steady = ($urandom_range(0, 3) == 0);
    while (sent < stop) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      if (chan_count != 0 && $urandom_range(0, 99) < 5) begin
        fill_channel();
      end else begin
        random_op();
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] plan [8];
    plan = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2};

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FN_SET_CHAN;
    req_if.channel     = '0;
    req_if.source_kind = '0;
    req_if.gain_in     = '0;
    rsp_if.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // count is zero out of reset: every channel is rejected
    send_op(FN_ADD, 4'd0, 5'd0, 16'h0000);
    send_op(FN_SET_CHAN, 4'd15, 5'd31, 16'hFFFF);
    write_count(4'd8);

    send_op(FN_SET_CHAN, 4'd7, 5'd31, 16'hFFFF);
    send_op(FN_SET_CHAN, 4'd8, 5'd0, 16'h0000);
    send_op(FN_ADD, 4'd0, 5'd0, 16'h0000);
    send_op(FN_ADD, 4'd0, 5'd0, 16'h0000);
    send_op(FN_ADD, 4'd0, 5'd17, 16'hFFFF);
    send_op(FN_ADD, 4'd0, 5'd18, 16'h0000);
    send_op(FN_GET, 4'd0, 5'd31, 16'h0000);
    send_op(FN_SET_SRC, 4'd0, 5'd0, 16'hFFFF);
    send_op(FN_GET, 4'd0, 5'd0, 16'h0000);
    send_op(FN_HAS, 4'd0, 5'd17, 16'h0000);
    // gain of an inactive type lands in the cache and comes back on add
    send_op(FN_SET_SRC, 4'd0, 5'd5, 16'h1234);
    send_op(FN_GET, 4'd0, 5'd5, 16'h0000);
    send_op(FN_ADD, 4'd0, 5'd5, 16'h0000);
    send_op(FN_GET, 4'd0, 5'd5, 16'h0000);
    send_op(FN_REMOVE, 4'd0, 5'd0, 16'h0000);
    send_op(FN_REMOVE, 4'd0, 5'd0, 16'h0000);
    send_op(FN_GET, 4'd0, 5'd0, 16'h0000);
    send_op(FN_HAS, 4'd0, 5'd0, 16'h0000);
    send_op(FN_GET, 4'd0, 5'd5, 16'h0000);
    send_op(FN_SET_CHAN, 4'd0, 5'd5, 16'h0000);
    send_op(FN_SPARE_LO, 4'd15, 5'd31, 16'hFFFF);
    send_op(FN_SPARE_HI, 4'd0, 5'd0, 16'h0000);

    foreach (plan[p]) begin
      write_count(plan[p]);
      random_phase((plan[p] == 0) ? 30 : 125);
    end

    drain();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
